// ===== hdl/bat_pkg.sv =====
// ----------------------------------------------------------------------------
// bat_pkg
// Shared types and constants for the advertiser address table.
// ----------------------------------------------------------------------------
package bat_pkg;

    localparam logic [7:0] EVT_PACKET   = 8'h04;
    localparam logic [7:0] EVT_LE_META  = 8'h3E;
    localparam logic [7:0] SUB_ADV_RPT  = 8'h02;
    localparam logic [3:0] MIN_LENGTH   = 4'd14;
    localparam logic [3:0] POS_EVT      = 4'd0;
    localparam logic [3:0] POS_META     = 4'd1;
    localparam logic [3:0] POS_SUB      = 4'd3;
    localparam logic [3:0] ADDR_FIRST   = 4'd7;
    localparam logic [3:0] ADDR_LAST    = 4'd12;

    typedef enum logic [1:0] {
        ST_UPDATED  = 2'd0,
        ST_ADDED    = 2'd1,
        ST_FULL     = 2'd2,
        ST_REJECTED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_READ,
        TS_CMP,
        TS_MISS
    } t_tbl_state;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              last_byte;
        logic signed [7:0] signal_dbm;
        logic [31:0]       now_tick;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  entry_index;
        logic [6:0]  devices_known;
        logic [31:0] packet_total;
    } t_out_item;

    typedef struct packed {
        logic    done;
        t_status status;
    } t_tbl_done;

endpackage

// ===== hdl/bat_table.sv =====
// ----------------------------------------------------------------------------
// bat_table
// Address table with a sequential search: each entry is read in one state and
// compared in the next, through a single 48-bit comparator.
// ----------------------------------------------------------------------------
module bat_table
    import bat_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [47:0]            i_key,
    input  logic signed [7:0]      i_signal,
    input  logic [31:0]            i_tick,
    output t_tbl_done              o_done,
    output logic [IW-1:0]          o_index,
    output logic [CW-1:0]          o_count
);

    logic [47:0]       mem_address [TABLE_DEPTH];
    logic signed [7:0] mem_signal  [TABLE_DEPTH];
    logic [31:0]       mem_tick    [TABLE_DEPTH];

    t_tbl_state        r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_count, n_count;
    logic [47:0]       r_key;
    logic signed [7:0] r_signal;
    logic [31:0]       r_tick;
    logic [47:0]       r_rd_address;
    t_tbl_done         r_done, n_done;
    logic [IW-1:0]     r_res_idx, n_res_idx;

    logic              rd_en;
    logic              wr_en;
    logic              wr_addr_en;
    logic [IW-1:0]     wr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
            r_count <= '0;
            r_done  <= '{done: 1'b0, status: ST_UPDATED};
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_res_idx <= n_res_idx;
        if (i_start) begin
            r_key    <= i_key;
            r_signal <= i_signal;
            r_tick   <= i_tick;
        end
    end

    // table storage, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_signal[wr_idx] <= r_signal;
            mem_tick[wr_idx]   <= r_tick;
        end
        if (wr_addr_en) begin
            mem_address[wr_idx] <= r_key;
        end
        if (rd_en) begin
            r_rd_address <= mem_address[r_idx];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_count    = r_count;
        n_done     = '{done: 1'b0, status: ST_UPDATED};
        n_res_idx  = r_res_idx;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr_en = 1'b0;
        wr_idx     = r_idx;
        unique case (r_state)
            TS_IDLE: begin
                if (i_start) begin
                    n_idx   = '0;
                    n_state = (r_count == '0) ? TS_MISS : TS_READ;
                end
            end
            TS_READ: begin
                rd_en   = 1'b1;
                n_state = TS_CMP;
            end
            TS_CMP: begin
                if (r_rd_address == r_key) begin
                    wr_en     = 1'b1;
                    n_done    = '{done: 1'b1, status: ST_UPDATED};
                    n_res_idx = r_idx;
                    n_state   = TS_IDLE;
                end else if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_state = TS_MISS;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = TS_READ;
                end
            end
            TS_MISS: begin
                n_state = TS_IDLE;
                if (r_count != CW'(TABLE_DEPTH)) begin
                    wr_idx     = r_count[IW-1:0];
                    wr_en      = 1'b1;
                    wr_addr_en = 1'b1;
                    n_count    = r_count + CW'(1);
                    n_done     = '{done: 1'b1, status: ST_ADDED};
                    n_res_idx  = r_count[IW-1:0];
                end else begin
                    n_done    = '{done: 1'b1, status: ST_FULL};
                    n_res_idx = '0;
                end
            end
            default: n_state = TS_IDLE;
        endcase
    end

    assign o_done  = r_done;
    assign o_index = r_res_idx;
    assign o_count = r_count;

endmodule

// ===== hdl/ble_advertiser_address_table_unit.sv =====
// ----------------------------------------------------------------------------
// ble_advertiser_address_table_unit
// Parses HCI event bytes, checks for an LE advertising report and keeps a
// table of advertiser addresses with signal strength and last-seen tick.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  in       input      i_in_valid / o_in_stall  t_in_item, one event byte
//  out      output     o_out_valid / i_out_stall t_out_item, one per event
//
//  Non-final bytes are taken whenever no search runs. A final byte that closes
//  a rejected event gives its result the next cycle. A valid report runs the
//  table search, which reads and compares the entries in turn through the
//  single comparator and the table's read port (none read when empty).
//  Reset is synchronous and clears framing, entry count and packet count.
//  A pending result blocks only a final byte; input stalls during a search.
// ----------------------------------------------------------------------------
module ble_advertiser_address_table_unit
    import bat_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [3:0]    r_pos;
    logic          r_hdr_good;
    logic [47:0]   r_addr;
    logic [31:0]   r_reports;
    logic          r_busy;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          in_accept;
    logic          hdr_bad;
    logic          hdr_now;
    logic [47:0]   addr_now;
    logic          report_ok;
    logic          tbl_start;
    logic          reject;
    logic          out_free;
    t_tbl_done     tbl_done;
    logic [IW-1:0] tbl_index;
    logic [CW-1:0] tbl_count;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_busy || (i_in_data.last_byte && !out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        hdr_bad = ((r_pos == POS_EVT)  && (i_in_data.data_byte != EVT_PACKET))  ||
                  ((r_pos == POS_META) && (i_in_data.data_byte != EVT_LE_META)) ||
                  ((r_pos == POS_SUB)  && (i_in_data.data_byte != SUB_ADV_RPT));
        hdr_now = r_hdr_good && !hdr_bad;
        if (r_pos >= ADDR_FIRST && r_pos <= ADDR_LAST) begin
            addr_now = {r_addr[39:0], i_in_data.data_byte};
        end else begin
            addr_now = r_addr;
        end
        // pos saturates at the minimum length, so pos + 1 >= 14 is pos >= 13
        report_ok = hdr_now && (r_pos >= MIN_LENGTH - 4'd1);
    end

    assign tbl_start = in_accept && i_in_data.last_byte && report_ok;
    assign reject    = in_accept && i_in_data.last_byte && !report_ok;

    bat_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (tbl_start),
        .i_key    (addr_now),
        .i_signal (i_in_data.signal_dbm),
        .i_tick   (i_in_data.now_tick),
        .o_done   (tbl_done),
        .o_index  (tbl_index),
        .o_count  (tbl_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_hdr_good  <= 1'b1;
            r_addr      <= '0;
            r_reports   <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                if (i_in_data.last_byte) begin
                    r_pos      <= '0;
                    r_hdr_good <= 1'b1;
                    r_addr     <= '0;
                end else begin
                    r_hdr_good <= hdr_now;
                    r_addr     <= addr_now;
                    if (r_pos < MIN_LENGTH) begin
                        r_pos <= r_pos + 4'd1;
                    end
                end
            end
            if (tbl_start) begin
                r_reports <= r_reports + 32'd1;
                r_busy    <= 1'b1;
            end else if (tbl_done.done) begin
                r_busy <= 1'b0;
            end
            if (reject || tbl_done.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (reject) begin
            r_out.status        <= ST_REJECTED;
            r_out.entry_index   <= '0;
            r_out.devices_known <= 7'(tbl_count);
            r_out.packet_total  <= r_reports;
        end else if (tbl_done.done) begin
            r_out.status        <= tbl_done.status;
            r_out.entry_index   <= 6'(tbl_index);
            r_out.devices_known <= 7'(tbl_count);
            r_out.packet_total  <= r_reports;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_done.done |-> r_busy)
        else $error("table result without a search in progress");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_start |-> !r_busy)
        else $error("search started while another is running");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (reject || tbl_done.done) |-> out_free)
        else $error("pending result overwritten");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");
`endif

endmodule

// ===== tb/sv/tb_ble_advertiser_address_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_ble_advertiser_address_table_unit
// Self-checking bench for the advertiser address table. HCI event bytes are
// queued up front and driven with random gaps; every accepted byte runs
// through an in-bench model of the framing and table, and each result that
// leaves the block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ble_advertiser_address_table_unit;
    import bat_pkg::*;

    localparam int TBL_DEPTH  = 64;
    localparam int DRAIN_WAIT = 2 * TBL_DEPTH + 8;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        t_in_item item;
        bit       sync_first;   // wait for all results before offering this byte
    } t_stim;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    ble_advertiser_address_table_unit #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus store and event builders
    // ------------------------------------------------------------------
    t_stim       pend_q[$];
    logic [7:0]  evt_bytes[$];
    logic [47:0] addr_pool[$];
    int          n_items = 0;

    task automatic report_bytes(input logic [47:0] addr, input int len);
        int i;
        evt_bytes.delete();
        evt_bytes.push_back(EVT_PACKET);
        evt_bytes.push_back(EVT_LE_META);
        evt_bytes.push_back(8'($urandom));
        evt_bytes.push_back(SUB_ADV_RPT);
        for (i = 0; i < 3; i++) evt_bytes.push_back(8'($urandom));
        for (i = 0; i < 6; i++) evt_bytes.push_back(addr[47 - 8 * i -: 8]);
        while (evt_bytes.size() < len) evt_bytes.push_back(8'($urandom));
    endtask

    // Queue the first n bytes of evt_bytes; sig/tick matter only on the last one.
    task automatic flush_event(input int n, input logic [7:0] sig, input logic [31:0] tick,
                               input bit sync);
        t_stim s;
        int    i;
        for (i = 0; i < n; i++) begin
            s.item.data_byte  = evt_bytes[i];
            s.item.last_byte  = (i == n - 1);
            s.item.signal_dbm = (i == n - 1) ? sig : 8'($urandom);
            s.item.now_tick   = (i == n - 1) ? tick : $urandom;
            s.sync_first      = sync && (i == 0);
            pend_q.push_back(s);
            n_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------
    logic [3:0]  fr_pos;
    logic        fr_hdr_ok;
    logic [47:0] fr_addr;
    logic [47:0] dev_addr [TBL_DEPTH];
    logic [7:0]  dev_sig  [TBL_DEPTH];
    logic [31:0] dev_tick [TBL_DEPTH];
    logic [6:0]  dev_count;
    logic [31:0] rpt_total;
    t_out_item   expected_q[$];
    int          stat_cnt[4] = '{0, 0, 0, 0};

    task automatic track_event_byte(input t_in_item it);
        t_out_item  res;
        logic [3:0] pos;
        bit         hit;
        int         k;
        pos = fr_pos;
        if ((pos == POS_EVT && it.data_byte != EVT_PACKET) ||
            (pos == POS_META && it.data_byte != EVT_LE_META) ||
            (pos == POS_SUB && it.data_byte != SUB_ADV_RPT))
            fr_hdr_ok = 1'b0;
        if (pos >= ADDR_FIRST && pos <= ADDR_LAST)
            fr_addr = {fr_addr[39:0], it.data_byte};
        if (fr_pos < MIN_LENGTH)
            fr_pos = fr_pos + 4'd1;
        if (it.last_byte) begin
            res.status      = ST_REJECTED;
            res.entry_index = '0;
            if (pos >= MIN_LENGTH - 4'd1 && fr_hdr_ok) begin
                hit = 1'b0;
                for (k = 0; k < int'(dev_count); k++) begin
                    if (!hit && dev_addr[k] == fr_addr) begin
                        dev_sig[k]      = it.signal_dbm;
                        dev_tick[k]     = it.now_tick;
                        res.status      = ST_UPDATED;
                        res.entry_index = 6'(k);
                        hit             = 1'b1;
                    end
                end
                if (!hit) begin
                    if (int'(dev_count) < TBL_DEPTH) begin
                        dev_addr[dev_count[$clog2(TBL_DEPTH)-1:0]] = fr_addr;
                        dev_sig[dev_count[$clog2(TBL_DEPTH)-1:0]]  = it.signal_dbm;
                        dev_tick[dev_count[$clog2(TBL_DEPTH)-1:0]] = it.now_tick;
                        res.entry_index     = 6'(dev_count);
                        dev_count           = dev_count + 7'd1;
                        res.status          = ST_ADDED;
                    end else begin
                        res.status = ST_FULL;
                    end
                end
                rpt_total = rpt_total + 32'd1;
            end
            res.devices_known = dev_count;
            res.packet_total  = rpt_total;
            expected_q.push_back(res);
            stat_cnt[res.status]++;
            fr_pos    = '0;
            fr_hdr_ok = 1'b1;
            fr_addr   = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: accept bookkeeping, prediction and result check
    // ------------------------------------------------------------------
    logic in_fire = 1'b0;
    int   n_in    = 0;
    int   n_out   = 0;
    int   n_err   = 0;

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            in_fire   <= 1'b0;
            fr_pos    = '0;
            fr_hdr_ok = 1'b1;
            fr_addr   = '0;
            dev_count = '0;
            rpt_total = '0;
        end else begin
            in_fire <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                n_in++;
                track_event_byte(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                n_out++;
                if (expected_q.size() == 0) begin
                    n_err++;
                    $error("result with no request pending: status %0d index %0d",
                           o_out_data.status, o_out_data.entry_index);
                end else begin
                    want = expected_q.pop_front();
                    if (o_out_data.status !== want.status) begin
                        n_err++;
                        $error("status: expected %0d, actual %0d",
                               want.status, o_out_data.status);
                    end
                    if (o_out_data.entry_index !== want.entry_index) begin
                        n_err++;
                        $error("entry_index: expected %0d, actual %0d",
                               want.entry_index, o_out_data.entry_index);
                    end
                    if (o_out_data.devices_known !== want.devices_known) begin
                        n_err++;
                        $error("devices_known: expected %0d, actual %0d",
                               want.devices_known, o_out_data.devices_known);
                    end
                    if (o_out_data.packet_total !== want.packet_total) begin
                        n_err++;
                        $error("packet_total: expected %0d, actual %0d",
                               want.packet_total, o_out_data.packet_total);
                    end
                end
            end
        end
    end

    // no random idling on either side over this stretch of request bytes
    function automatic bit quiet_window();
        return n_in >= 600 && n_in < 900;
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_stim nxt;
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (pend_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pend_q[0].sync_first && expected_q.size() != 0) begin
                i_in_valid <= 1'b0;
            end else if (!quiet_window() && $urandom_range(99) < 21) begin
                i_in_valid <= 1'b0;
            end else begin
                nxt = pend_q.pop_front();
                i_in_data  <= nxt.item;
                i_in_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall plus one long hold-off
    // ------------------------------------------------------------------
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && n_in >= 300) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_LEN - 1;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= quiet_window() ? 1'b0 : ($urandom_range(99) < 21);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int          pick;
        int          len;
        int          n_evt;
        int          i;
        int          fails;
        bit          sync;
        bit          fresh;
        logic [47:0] addr;

        // long report, all-ones address, extreme signal and tick
        report_bytes(48'hFFFF_FFFF_FFFF, 15);
        flush_event(15, 8'h7F, 32'hFFFF_FFFF, 1'b0);
        addr_pool.push_back(48'hFFFF_FFFF_FFFF);
        // one-byte event of zero: bad header and short
        evt_bytes.delete();
        evt_bytes.push_back(8'h00);
        flush_event(1, 8'h80, 32'h0, 1'b0);
        // good header closed before the address
        report_bytes(48'h0, 14);
        flush_event(4, 8'h00, 32'h0, 1'b0);

        n_evt = 0;
        while (n_items < 800) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(7) == 0) ? $urandom_range(20, 15) : 14;
            sync = (n_evt == 30) || ($urandom_range(39) == 0);
            if (pick < 80) begin
                fresh = $urandom_range(99) < ((addr_pool.size() < TBL_DEPTH) ? 85 : 30);
                if (!fresh) begin
                    addr = addr_pool[$urandom_range(addr_pool.size() - 1)];
                end else begin
                    if ($urandom_range(9) == 0)
                        // near miss: one bit away from a known address
                        addr = addr_pool[$urandom_range(addr_pool.size() - 1)] ^
                               (48'd1 << $urandom_range(47));
                    else
                        addr = {16'($urandom), 32'($urandom)};
                    addr_pool.push_back(addr);
                end
                report_bytes(addr, len);
                flush_event(len, 8'($urandom), $urandom, sync);
            end else if (pick < 88) begin
                report_bytes(addr_pool[$urandom_range(addr_pool.size() - 1)], len);
                case ($urandom_range(2))
                    0: i = int'(POS_EVT);
                    1: i = int'(POS_META);
                    default: i = int'(POS_SUB);
                endcase
                evt_bytes[i] = evt_bytes[i] ^ 8'($urandom_range(255, 1));
                flush_event(len, 8'($urandom), $urandom, sync);
            end else if (pick < 95) begin
                report_bytes(addr_pool[$urandom_range(addr_pool.size() - 1)], 14);
                flush_event($urandom_range(13, 1), 8'($urandom), $urandom, sync);
            end else begin
                evt_bytes.delete();
                len = $urandom_range(20, 1);
                for (i = 0; i < len; i++) evt_bytes.push_back(8'($urandom));
                flush_event(len, 8'($urandom), $urandom, sync);
            end
            n_evt++;
        end

        while (pend_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        fails = n_err;
        if (expected_q.size() != 0) begin
            fails = fails + expected_q.size();
            $error("%0d predicted results never arrived", expected_q.size());
        end
        $display("Ran %0d request bytes in %0d events, %0d results checked.",
                 n_in, stat_cnt[0] + stat_cnt[1] + stat_cnt[2] + stat_cnt[3], n_out);
        $display("Outcomes: %0d added, %0d updated, %0d table full, %0d rejected.",
                 stat_cnt[ST_ADDED], stat_cnt[ST_UPDATED], stat_cnt[ST_FULL],
                 stat_cnt[ST_REJECTED]);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
